### hdl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape.
// No dependencies.
package jsu_pkg;

  localparam int ByteW            = 8;
  localparam int LimitW           = 12;
  localparam int MaxBeats         = 3;
  localparam int QueueDepth       = 4;
  localparam int CountWidthDef    = 12;
  localparam int ApbAddrW         = 3;
  localparam int ApbDataW         = 32;
  localparam int OutDataW         = 24;

  localparam logic [LimitW-1:0] LimitReset = 12'd255;

  // Register word index on the configuration port.
  localparam logic RegOutLimit = 1'b0;

  // Characters that matter to the scanner.
  localparam logic [ByteW-1:0] CharBackslash = 8'h5C;
  localparam logic [ByteW-1:0] CharN         = 8'h6E;
  localparam logic [ByteW-1:0] CharT         = 8'h74;
  localparam logic [ByteW-1:0] CharR         = 8'h72;
  localparam logic [ByteW-1:0] CharB         = 8'h62;
  localparam logic [ByteW-1:0] CharF         = 8'h66;
  localparam logic [ByteW-1:0] CharU         = 8'h75;
  localparam logic [ByteW-1:0] CtrlLf        = 8'h0A;
  localparam logic [ByteW-1:0] CtrlTab       = 8'h09;
  localparam logic [ByteW-1:0] CtrlCr        = 8'h0D;
  localparam logic [ByteW-1:0] CtrlBs        = 8'h08;
  localparam logic [ByteW-1:0] CtrlFf        = 8'h0C;

  // Code point limits and UTF-8 framing.
  localparam logic [15:0] CpSurLo   = 16'hD800;
  localparam logic [15:0] CpSurHi   = 16'hDFFF;
  localparam logic [15:0] CpRepl    = 16'hFFFD;
  localparam logic [15:0] CpOneMax  = 16'h0080;
  localparam logic [15:0] CpTwoMax  = 16'h0800;
  localparam logic [ByteW-1:0] Utf8Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Utf8Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Utf8Cont  = 8'h80;
  localparam logic [ByteW-1:0] Utf8Mask  = 8'h3F;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEscape = 2'd1,
    ModeHex    = 2'd2
  } scan_mode_e;

  // Everything one input byte produces: up to three output bytes, or a bare
  // end marker when nbytes is zero and tlast is set.
  typedef struct packed {
    logic [MaxBeats-1:0][ByteW-1:0] bytes;
    logic [1:0]                     nbytes;
    logic                           tlast;
    logic [LimitW-1:0]              length;
  } bundle_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

### hdl/jsu_front.sv
// Front end of the JSON string unescaper: accepts input beats, runs the
// escape scanner and byte counter, and pushes one bundle per productive beat.
// Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LimitW-1:0] limit_i,
  input  logic              in_valid_i,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output bundle_t           push_data_o
);

  localparam int CntW = COUNT_WIDTH;
  localparam int ExtW = (CntW > LimitW) ? CntW : LimitW;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef struct packed {
    scan_mode_e      mode;
    logic            full;
    logic [CntW-1:0] wcnt;
  } ctx_t;

  typedef struct packed {
    ctx_t            ctx;
    logic            emit;
    logic [ByteW-1:0] ch;
  } step_t;

  scan_mode_e       mode_q;
  logic             full_q;
  logic [CntW-1:0]  wcnt_q;
  logic [1:0]       held_cnt_q, held_cnt_d;
  logic [ByteW-1:0] held_q [3];
  logic             hold_en;

  ctx_t             cur_ctx, nxt_ctx;
  step_t            st;
  logic [ExtW-1:0]  eff_lim, lim_ext, max_ext, room;
  logic [ByteW-1:0] rep [3];
  logic [ByteW-1:0] dig [4];
  logic [4:0]       hv [4];
  logic             hex_ok;
  logic [15:0]      cp;
  logic [MaxBeats-1:0][ByteW-1:0] obytes;
  logic [1:0]       ocnt;
  logic             accept;
  logic [ExtW-1:0]  wcnt_ext;

  function automatic logic [CntW-1:0] sat_add(logic [CntW-1:0] w, logic [1:0] n);
    logic [CntW+1:0] s;
    s = {2'b00, w} + (CntW+2)'(n);
    return (s > {2'b00, CntMax}) ? CntMax : s[CntW-1:0];
  endfunction

  // One character through the plain and single-escape rules.
  function automatic step_t simple_step(ctx_t cx, logic [ByteW-1:0] c, logic last,
                                        logic [ExtW-1:0] eff);
    step_t r;
    r      = '0;
    r.ctx  = cx;
    r.ch   = c;
    r.emit = 1'b0;
    case (cx.mode)
      ModeEscape: begin
        r.ctx.mode = ModeNormal;
        r.emit     = 1'b1;
        case (c)
          CharN: r.ch = CtrlLf;
          CharT: r.ch = CtrlTab;
          CharR: r.ch = CtrlCr;
          CharB: r.ch = CtrlBs;
          CharF: r.ch = CtrlFf;
          CharU: begin
            r.emit = 1'b0;
            if (!last) r.ctx.mode = ModeHex;
          end
          default: r.ch = c;
        endcase
      end
      default: begin
        r.ctx.mode = ModeNormal;
        if (cx.full || (ExtW'(cx.wcnt) >= eff)) begin
          r.ctx.full = 1'b1;
        end else if ((c == CharBackslash) && !last) begin
          r.ctx.mode = ModeEscape;
        end else begin
          r.emit = 1'b1;
        end
      end
    endcase
    if (r.emit) r.ctx.wcnt = sat_add(cx.wcnt, 2'd1);
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    lim_ext = ExtW'(limit_i);
    max_ext = ExtW'(CntMax);
    eff_lim = (lim_ext > max_ext) ? max_ext : lim_ext;
    wcnt_ext = ExtW'(wcnt_q);
    room    = (wcnt_ext >= eff_lim) ? '0 : (eff_lim - wcnt_ext);
  end

  always_comb begin
    cur_ctx.mode = mode_q;
    cur_ctx.full = full_q;
    cur_ctx.wcnt = wcnt_q;
    nxt_ctx      = cur_ctx;
    held_cnt_d   = held_cnt_q;
    hold_en      = 1'b0;
    obytes       = '0;
    ocnt         = 2'd0;
    st           = '0;
    cp           = 16'd0;
    hex_ok       = 1'b1;
    dig[0] = held_q[0];
    dig[1] = held_q[1];
    dig[2] = held_q[2];
    dig[3] = in_byte_i;
    for (int i = 0; i < 4; i++) begin
      hv[i] = hex_val(dig[i]);
    end
    for (int j = 0; j < 3; j++) begin
      rep[j] = (2'(j) < held_cnt_q) ? held_q[j] : in_byte_i;
    end

    case (mode_q)
      ModeHex: begin
        if (held_cnt_q == 2'd3) begin
          for (int i = 0; i < 4; i++) begin
            hex_ok = hex_ok & hv[i][4];
          end
          cp = hex_ok ? {hv[0][3:0], hv[1][3:0], hv[2][3:0], hv[3][3:0]} : 16'd0;
          if (((cp >= CpSurLo) && (cp <= CpSurHi)) || (cp == 16'd0)) cp = CpRepl;
          if (cp < CpOneMax) begin
            if (room >= ExtW'(1)) begin
              obytes[0] = cp[7:0];
              ocnt      = 2'd1;
            end
          end else if (cp < CpTwoMax) begin
            if (room >= ExtW'(2)) begin
              obytes[0] = Utf8Lead2 | {3'b000, cp[10:6]};
              obytes[1] = Utf8Cont | (Utf8Mask & {2'b00, cp[5:0]});
              ocnt      = 2'd2;
            end
          end else if (room >= ExtW'(3)) begin
            obytes[0] = Utf8Lead3 | {4'h0, cp[15:12]};
            obytes[1] = Utf8Cont | (Utf8Mask & {2'b00, cp[11:6]});
            obytes[2] = Utf8Cont | (Utf8Mask & {2'b00, cp[5:0]});
            ocnt      = 2'd3;
          end
          nxt_ctx.mode = ModeNormal;
          nxt_ctx.wcnt = sat_add(wcnt_q, ocnt);
          held_cnt_d   = 2'd0;
        end else if (in_last_i) begin
          // Short unicode escape: the held characters and this one go back
          // through the plain rules, starting in normal mode.
          nxt_ctx.mode = ModeNormal;
          for (int j = 0; j < 3; j++) begin
            if (2'(j) <= held_cnt_q) begin
              st      = simple_step(nxt_ctx, rep[j], (2'(j) == held_cnt_q), eff_lim);
              nxt_ctx = st.ctx;
              if (st.emit) begin
                obytes[ocnt] = st.ch;
                ocnt         = ocnt + 2'd1;
              end
            end
          end
          held_cnt_d = 2'd0;
        end else begin
          hold_en    = 1'b1;
          held_cnt_d = held_cnt_q + 2'd1;
        end
      end
      default: begin
        st      = simple_step(cur_ctx, in_byte_i, in_last_i, eff_lim);
        nxt_ctx = st.ctx;
        if (st.emit) begin
          obytes[0] = st.ch;
          ocnt      = 2'd1;
        end
        if (st.ctx.mode == ModeHex) held_cnt_d = 2'd0;
      end
    endcase
  end

  always_comb begin
    push_o             = accept && ((ocnt != 2'd0) || in_last_i);
    push_data_o.bytes  = obytes;
    push_data_o.nbytes = ocnt;
    push_data_o.tlast  = in_last_i;
    push_data_o.length = in_last_i ? LimitW'(ExtW'(nxt_ctx.wcnt)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeNormal;
      full_q     <= 1'b0;
      wcnt_q     <= '0;
      held_cnt_q <= 2'd0;
    end else if (accept) begin
      if (in_last_i) begin
        mode_q     <= ModeNormal;
        full_q     <= 1'b0;
        wcnt_q     <= '0;
        held_cnt_q <= 2'd0;
      end else begin
        mode_q     <= nxt_ctx.mode;
        full_q     <= nxt_ctx.full;
        wcnt_q     <= nxt_ctx.wcnt;
        held_cnt_q <= held_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_en) begin
      held_q[held_cnt_q] <= in_byte_i;
    end
  end

endmodule

### hdl/jsu_queue.sv
// Small bundle queue between the scanner and the output serializer.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  bundle_t         mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### hdl/jsu_back.sv
// Output serializer: splits each queued bundle into beats, one per cycle while
// out_ready_i allows, through a registered output stage.  Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bundle_t           head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              out_bvalid_o,
  output logic              out_last_o,
  output logic [LimitW-1:0] out_len_o
);

  logic [1:0]        beat_q, beat_d;
  logic              valid_q, valid_d;
  logic [ByteW-1:0]  byte_q;
  logic              bvalid_q, last_q;
  logic [LimitW-1:0] len_q;
  logic              load, final_beat;
  logic [1:0]        nbeats;

  always_comb begin
    nbeats     = (head_i.nbytes == 2'd0) ? 2'd1 : head_i.nbytes;
    final_beat = (beat_q == (nbeats - 2'd1));
    load       = !empty_i && (!valid_q || out_ready_i);
    pop_o      = load && final_beat;
    beat_d     = beat_q;
    if (load) beat_d = final_beat ? 2'd0 : (beat_q + 2'd1);
    valid_d    = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      beat_q  <= beat_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= (head_i.nbytes == 2'd0) ? '0 : head_i.bytes[beat_q];
      bvalid_q <= (head_i.nbytes != 2'd0);
      last_q   <= head_i.tlast && final_beat;
      len_q    <= (head_i.tlast && final_beat) ? head_i.length : '0;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign out_bvalid_o = bvalid_q;
  assign out_last_o   = last_q;
  assign out_len_o    = len_q;

endmodule

### hdl/json_string_unescape.sv
// JSON string unescaper, top level: configuration port and stream wiring.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
// Feed the bytes of one JSON string body, one per beat, with tlast on the
// final byte; the block returns the decoded bytes, UTF-8 for \uXXXX escapes,
// and marks the last result of the token with tlast and its total length.
// A token that yields no bytes returns one bare end beat with tuser low.
// Input takes one beat per cycle while the queue is not full; the serializer
// sends one beat per cycle while m_axis_tready is high, so an escape that
// expands to several bytes holds the output for one beat per byte, and a
// four-entry queue between scanner and serializer absorbs the difference.
// Results are registered in the queue and output stage. out_limit (address 0)
// caps the bytes written per token and should only be changed between tokens.
module json_string_unescape import jsu_pkg::*; #(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,  // [7:0] in_byte
  input  logic                s_axis_tlast,  // in_last
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [7:0] out_byte, [19:8] out_length
  output logic                m_axis_tlast,  // token_end
  output logic                m_axis_tuser   // byte_valid
);

  logic [LimitW-1:0] limit_q;
  logic              cfg_wr;
  logic              push, pop, q_full, q_empty;
  bundle_t           push_data, head;
  logic [ByteW-1:0]  out_byte;
  logic [LimitW-1:0] out_len;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegOutLimit);
  assign prdata = (paddr[2] == RegOutLimit) ? ApbDataW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_wr) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  jsu_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  jsu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .out_bvalid_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .out_len_o    (out_len)
  );

  assign m_axis_tdata = {4'h0, out_len, out_byte};

endmodule
